FILE: rtl/dtp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtp_pkg
// Types and codes for the decimal text to int32 parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic signed [31:0] parsed_value;
    logic [2:0]         error_code;
  } out_t;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_SYMBOL      = 3'd1;
  localparam logic [2:0] ERR_MINUS_PLACE = 3'd2;
  localparam logic [2:0] ERR_MINUS_TWICE = 3'd3;
  localparam logic [2:0] ERR_LEAD_ZERO   = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int MAG_W = 31;

endpackage
`default_nettype wire

FILE: rtl/decimal_text_to_int32_parser_unit.sv
`default_nettype none
// The last character passes the input register, then its state update writes the
//   result register; a held result can keep it waiting in the input register.
// Throughput: one character beat per cycle, except that a held result stalls a
//   last-character beat; the times-ten accumulate feeding the magnitude is combinational.
// Reset: synchronous, active high; clears accumulator state and both valid flags.
// ----------------------------------------------------------------------------
// decimal_text_to_int32_parser_unit
// Streams characters of a decimal string and emits a signed value and error code.
// ----------------------------------------------------------------------------
module decimal_text_to_int32_parser_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dtp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dtp_pkg::out_t      out_data
);

  localparam int PROD_W = dtp_pkg::MAG_W + 4;

  logic                      s1_valid;
  dtp_pkg::in_t              s1_data;
  logic                      s1_advance;
  logic                      s1_fire;

  logic [dtp_pkg::MAG_W-1:0] magnitude, magnitude_next;
  logic                      negative_seen, negative_seen_next;
  logic                      leading_space_done, leading_space_done_next;
  logic [2:0]                pending_error, pending_error_next;

  logic [7:0]                c;
  logic                      blank;
  logic [3:0]                digit;
  logic [PROD_W-1:0]         prod;
  logic signed [31:0]        value;

  assign s1_advance = !s1_data.last_char || !out_valid || out_ready;
  assign s1_fire    = s1_valid && s1_advance;
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  always_comb begin
    c     = s1_data.char_code;
    blank = c inside {dtp_pkg::CH_SPACE, dtp_pkg::CH_TAB, dtp_pkg::CH_LF, dtp_pkg::CH_CR};
    digit = 4'(c - dtp_pkg::CH_ZERO);
    // x10 as shift-add
    prod  = ({4'd0, magnitude} << 3) + ({4'd0, magnitude} << 1)
          + {{(PROD_W-4){1'b0}}, digit};

    magnitude_next          = magnitude;
    negative_seen_next      = negative_seen;
    leading_space_done_next = leading_space_done;
    pending_error_next      = pending_error;

    if (pending_error == dtp_pkg::ERR_NONE && !(!leading_space_done && blank)) begin
      leading_space_done_next = 1'b1;
      if (c == dtp_pkg::CH_MINUS) begin
        if (magnitude != '0) begin
          pending_error_next = dtp_pkg::ERR_MINUS_PLACE;
        end else if (negative_seen) begin
          pending_error_next = dtp_pkg::ERR_MINUS_TWICE;
        end else begin
          negative_seen_next = 1'b1;
        end
      end else if (c < dtp_pkg::CH_ZERO || c > dtp_pkg::CH_NINE) begin
        pending_error_next = dtp_pkg::ERR_SYMBOL;
      end else if (c == dtp_pkg::CH_ZERO && magnitude == '0) begin
        pending_error_next = dtp_pkg::ERR_LEAD_ZERO;
      end else if (prod[PROD_W-1:dtp_pkg::MAG_W] != '0) begin
        pending_error_next = dtp_pkg::ERR_OVERFLOW;
      end else begin
        magnitude_next = prod[dtp_pkg::MAG_W-1:0];
      end
    end

    if (pending_error_next != dtp_pkg::ERR_NONE) begin
      value = '0;
    end else if (negative_seen_next) begin
      value = -$signed({1'b0, magnitude_next});
    end else begin
      value = $signed({1'b0, magnitude_next});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude          <= '0;
      negative_seen      <= 1'b0;
      leading_space_done <= 1'b0;
      pending_error      <= dtp_pkg::ERR_NONE;
    end else if (s1_fire) begin
      if (s1_data.last_char) begin
        magnitude          <= '0;
        negative_seen      <= 1'b0;
        leading_space_done <= 1'b0;
        pending_error      <= dtp_pkg::ERR_NONE;
      end else begin
        magnitude          <= magnitude_next;
        negative_seen      <= negative_seen_next;
        leading_space_done <= leading_space_done_next;
        pending_error      <= pending_error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_data.last_char) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_data.last_char) begin
      out_data.parsed_value <= value;
      out_data.error_code   <= pending_error_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dtp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks for the parser, bound to the top level.
// ----------------------------------------------------------------------------
module dtp_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire dtp_pkg::out_t out_data
);

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error_code != dtp_pkg::ERR_NONE |-> out_data.parsed_value == 32'sd0)
    else $error("nonzero value with error");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.error_code <= dtp_pkg::ERR_OVERFLOW)
    else $error("error code out of range");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.parsed_value != 32'sh8000_0000)
    else $error("most negative value emitted");

  // a rising result needs an earlier accepted input beat, or a stalled input
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 1))
    else $error("result without input beat");

endmodule

bind decimal_text_to_int32_parser_unit dtp_checker u_dtp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the decimal text to int32 parser against a cycle-free predictor:
// directed strings for each error path except overflow, then random strings under several
// idle patterns, and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUIET_LIMIT = 2000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  dtp_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  dtp_pkg::out_t out_data;

  decimal_text_to_int32_parser_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [dtp_pkg::MAG_W-1:0] acc_mag = '0;
  logic                      acc_neg = 1'b0;
  logic                      acc_started = 1'b0;
  logic [2:0]                acc_err = dtp_pkg::ERR_NONE;
  dtp_pkg::out_t             parsed_q[$];

  int mismatches = 0;
  int src_idle = 0;
  int sink_idle = 0;
  int hold_len = 0;
  int hold_id = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  logic [7:0] blank_codes [4] = '{dtp_pkg::CH_SPACE, dtp_pkg::CH_TAB,
                                  dtp_pkg::CH_LF, dtp_pkg::CH_CR};
  longint corner_vals [8] = '{64'sd2147483647, 64'sd2147483648, -64'sd2147483648,
                              -64'sd2147483647, 64'sd214748364, 64'sd4294967295,
                              64'sd10000000000, -64'sd1000000000};

  function automatic logic is_blank(logic [7:0] c);
    return c == dtp_pkg::CH_SPACE || c == dtp_pkg::CH_TAB ||
           c == dtp_pkg::CH_LF || c == dtp_pkg::CH_CR;
  endfunction

  // Advance the predictor by one accepted character.
  task automatic parse_char(logic [7:0] c, logic last);
    logic [34:0]   nxt;
    dtp_pkg::out_t res;
    if (acc_err == dtp_pkg::ERR_NONE && (acc_started || !is_blank(c))) begin
      acc_started = 1'b1;
      if (c == dtp_pkg::CH_MINUS) begin
        if (acc_mag != '0) acc_err = dtp_pkg::ERR_MINUS_PLACE;
        else if (acc_neg) acc_err = dtp_pkg::ERR_MINUS_TWICE;
        else acc_neg = 1'b1;
      end else if (c < dtp_pkg::CH_ZERO || c > dtp_pkg::CH_NINE) begin
        acc_err = dtp_pkg::ERR_SYMBOL;
      end else if (c == dtp_pkg::CH_ZERO && acc_mag == '0) begin
        acc_err = dtp_pkg::ERR_LEAD_ZERO;
      end else begin
        nxt = 35'(acc_mag) * 35'd10 + 35'(c - dtp_pkg::CH_ZERO);
        if (nxt > 35'h7FFF_FFFF) acc_err = dtp_pkg::ERR_OVERFLOW;
        else acc_mag = nxt[dtp_pkg::MAG_W-1:0];
      end
    end
    if (last) begin
      res.error_code = acc_err;
      if (acc_err != dtp_pkg::ERR_NONE) res.parsed_value = '0;
      else if (acc_neg) res.parsed_value = -{1'b0, acc_mag};
      else res.parsed_value = {1'b0, acc_mag};
      parsed_q.push_back(res);
      acc_mag = '0;
      acc_neg = 1'b0;
      acc_started = 1'b0;
      acc_err = dtp_pkg::ERR_NONE;
    end
  endtask

  // Offer one character beat; returns in the step of the accepting edge.
  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_code: c, last_char: last};
    do @(posedge clk); while (!in_ready);
    parse_char(c, last);
  endtask

  task automatic send_string(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Mostly well-formed numbers; some corner values, corrupted strings and noise.
  task automatic send_random_string(output int n_sent);
    logic [7:0] txt[$];
    string      s;
    int         kind;
    int         i;
    kind = $urandom_range(9);
    if (kind == 7) begin
      s = $sformatf("%0d", corner_vals[$urandom_range(7)]);
      repeat ($urandom_range(1)) txt.push_back(blank_codes[$urandom_range(3)]);
      for (i = 0; i < s.len(); i++) txt.push_back(s[i]);
    end else if (kind == 9) begin
      repeat ($urandom_range(6, 1)) txt.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(2)) txt.push_back(blank_codes[$urandom_range(3)]);
      if ($urandom_range(1)) txt.push_back(dtp_pkg::CH_MINUS);
      txt.push_back(8'(dtp_pkg::CH_ZERO + $urandom_range(9, 1)));
      repeat ($urandom_range(9)) txt.push_back(8'(dtp_pkg::CH_ZERO + $urandom_range(9)));
      if (kind == 8) txt[$urandom_range(txt.size() - 1)] = 8'($urandom);
    end
    for (i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
    n_sent = txt.size();
  endtask

  // Sender goes quiet until every expected result has been seen.
  task automatic wait_drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (parsed_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed;
    send_string(" 7");
    send_string("\t-9");
    send_string("0");
    send_string("-0");
    send_string("--");
    send_string("5-");
    send_string("\n\r");
    send_string("-");
    send_string("1 5");
    send_string("/");
    send_string(":");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    wait_drain;
  endtask

  task automatic test_random(int s_idle, int r_idle, int n_chars);
    int sent;
    int n;
    src_idle = s_idle;
    sink_idle <= r_idle;
    sent = 0;
    while (sent < n_chars) begin
      send_random_string(n);
      sent += n;
    end
    wait_drain;
  endtask

  // Receiver holds off long enough for held results to stall the input.
  task automatic test_output_stall;
    int sent;
    int n;
    src_idle = 0;
    sink_idle <= 0;
    hold_len <= 400;
    hold_id <= hold_id + 1;
    sent = 0;
    while (sent < 40) begin
      send_random_string(n);
      sent += n;
    end
    wait_drain;
  endtask

  // receiver
  always @(posedge clk) begin
    if (hold_id != hold_seen) begin
      hold_seen <= hold_id;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  // result check
  always @(posedge clk) begin
    dtp_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (parsed_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d code=%0d", $time,
                 out_data.parsed_value, out_data.error_code);
        mismatches++;
      end else begin
        want = parsed_q.pop_front();
        if (out_data.parsed_value !== want.parsed_value) begin
          $display("%0t: parsed_value expected %0d actual %0d", $time,
                   want.parsed_value, out_data.parsed_value);
          mismatches++;
        end
        if (out_data.error_code !== want.error_code) begin
          $display("%0t: error_code expected %0d actual %0d", $time,
                   want.error_code, out_data.error_code);
          mismatches++;
        end
      end
    end
  end

  // watchdog: any beat on either side resets the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed;
    test_random(14, 61, 130);
    test_random(61, 14, 130);
    test_random(0, 0, 130);
    test_output_stall;
    repeat (10) @(posedge clk);
    if (mismatches == 0 && parsed_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
